/* design/sitd_pkg.sv */
// shared types and constants for the signed integer to decimal text block
package sitd_pkg;

    localparam int VALUE_W   = 32;
    localparam int DIGITS    = 10;
    localparam int DIGIT_W   = 4;
    localparam int CNT_W     = 4;
    localparam int QUOT_W    = 29;
    localparam int RECIP_SHR = 35;

    localparam logic [7:0]  CHAR_ZERO  = 8'd48;
    localparam logic [7:0]  CHAR_MINUS = 8'd45;
    // ceil(2^35 / 10): exact divide by ten for any 32-bit unsigned value
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic quot_zero;
        logic negative;
        logic one_left;
    } status_t;

endpackage

/* design/signed_int_to_decimal_ascii.sv */
// top level: signed 32-bit integer to decimal ascii text, one value per request and
// one text byte per output transfer; each digit takes a reciprocal multiply step
// (ST_MUL), then a remainder step (ST_DIV) on the shared divide-by-ten logic;
// a new value is taken only in idle, after the last byte of the previous one;
// bytes leave at one per cycle from an output register while m_ready stays high
// reset: synchronous active-low aresetn clears the controller and output valid
module signed_int_to_decimal_ascii (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sitd_pkg::VALUE_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_text_byte,
    output logic                                m_last_byte
);
    import sitd_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    sitd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic and storage
    sitd_datapath u_datapath (
        .aclk        (aclk),
        .cmd         (cmd),
        .s_value     (s_value),
        .status      (status),
        .m_text_byte (m_text_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

/* design/sitd_datapath.sv */
// datapath: magnitude, divide by ten, digit store and output register
module sitd_datapath (
    input  logic                                aclk,
    input  sitd_pkg::cmd_t                      cmd,
    input  logic signed [sitd_pkg::VALUE_W-1:0] s_value,
    output sitd_pkg::status_t                   status,
    output logic [7:0]                          m_text_byte,
    output logic                                m_last_byte
);
    import sitd_pkg::*;

    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic [CNT_W-1:0]   ndig_reg, ndig_next;
    logic [DIGIT_W-1:0] digits_reg [DIGITS];
    logic [7:0]         text_reg, text_next;
    logic               last_reg, last_next;

    logic [2*VALUE_W-1:0] prod;
    logic [DIGIT_W-1:0]   qten_lo;
    logic [DIGIT_W-1:0]   rem;
    logic [CNT_W-1:0]     rd_idx;
    logic [VALUE_W-1:0]   raw;

    // quotient by reciprocal multiply, remainder from the low nibble only
    assign raw     = $unsigned(s_value);
    assign prod    = 64'(mag_reg) * 64'(RECIP_TEN);
    assign qten_lo = 4'({quot_reg[0], 3'b000}) + 4'({quot_reg[2:0], 1'b0});
    assign rem     = mag_reg[DIGIT_W-1:0] - qten_lo;
    assign rd_idx  = ndig_reg - 4'd1;

    // next values of the working registers
    always_comb begin
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        ndig_next = ndig_reg;
        text_next = text_reg;
        last_next = last_reg;
        if (cmd.load) begin
            neg_next  = raw[VALUE_W-1];
            mag_next  = raw[VALUE_W-1] ? (32'd0 - raw) : raw;
            ndig_next = '0;
        end
        if (cmd.mul) begin
            quot_next = prod[RECIP_SHR +: QUOT_W];
        end
        if (cmd.div) begin
            mag_next  = VALUE_W'(quot_reg);
            ndig_next = ndig_reg + 4'd1;
        end
        if (cmd.emit_sign) begin
            text_next = CHAR_MINUS;
            last_next = 1'b0;
        end
        if (cmd.emit_digit) begin
            text_next = CHAR_ZERO + {4'b0000, digits_reg[rd_idx]};
            last_next = (ndig_reg == 4'd1);
            ndig_next = rd_idx;
        end
    end

    // register update
    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
        ndig_reg <= ndig_next;
        text_reg <= text_next;
        last_reg <= last_next;
        if (cmd.div) begin
            digits_reg[ndig_reg] <= rem;
        end
    end

    assign status.quot_zero = (quot_reg == '0);
    assign status.negative  = neg_reg;
    assign status.one_left  = (ndig_reg == 4'd1);

    assign m_text_byte = text_reg;
    assign m_last_byte = last_reg;

endmodule

/* design/sitd_ctrl.sv */
// controller: sequences division steps and byte output
module sitd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  sitd_pkg::status_t   status,
    output sitd_pkg::cmd_t      cmd
);
    import sitd_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MUL;
            end
            ST_MUL: state_next = ST_DIV;
            ST_DIV: begin
                if (!status.quot_zero) state_next = ST_MUL;
                else if (status.negative) state_next = ST_SIGN;
                else state_next = ST_DIGITS;
            end
            ST_SIGN: begin
                if (slot_free) state_next = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (slot_free && status.one_left) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_MUL:    cmd.mul = 1'b1;
            ST_DIV:    cmd.div = 1'b1;
            ST_SIGN:   cmd.emit_sign = slot_free;
            ST_DIGITS: cmd.emit_digit = slot_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit_sign || cmd.emit_digit) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
